// File: src/shiprrip_pkg.sv
// ----------------------------------------------------------------------------
// shiprrip_pkg
// Shared types and constants of the dead-block-aware RRIP replacement block.
// ----------------------------------------------------------------------------
package shiprrip_pkg;

  // Request kinds carried in the slave-side tuser.
  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STREAM_THR = 2'd0;
  localparam logic [1:0] CFG_REUSE_THR  = 2'd1;
  localparam logic [1:0] CFG_DECAY_INT  = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Field widths of one request and one result.
  localparam int SET_FIELD_W  = 11;
  localparam int WAY_FIELD_W  = 4;
  localparam int ADDR_W       = 64;
  localparam int PC_FIELD_W   = 6;
  localparam int IN_TDATA_W   = 88;
  localparam int OUT_TDATA_W  = 8;

  // Bit positions inside the slave-side tdata.
  localparam int SET_LSB  = 0;
  localparam int WAY_LSB  = SET_LSB + SET_FIELD_W;
  localparam int ADDR_LSB = WAY_LSB + WAY_FIELD_W;
  localparam int PC_LSB   = ADDR_LSB + ADDR_W;
  localparam int HIT_LSB  = PC_LSB + PC_FIELD_W;

  // Block address to signature: the line offset is dropped.
  localparam int LINE_SHIFT = 6;

  localparam int STREAM_ENTRIES = 2;

  localparam logic [1:0] CTR_MAX  = 2'd3;
  localparam logic [1:0] RRPV_FAR = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // capture a request and read its set
    logic exec;    // compute and write back the request
    logic clr;     // write reset values at the sweep counter
    logic sw_rd;   // read the set at the sweep counter
    logic sw_wr;   // write back the decayed set
    logic cnt_inc;
    logic cnt_clr;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_victim;
    logic out_full;
    logic sweep_req;
    logic clr_last;
    logic set_last;
  } status_t;

endpackage

// File: src/shiprrip_ctrl.sv
// ----------------------------------------------------------------------------
// shiprrip_ctrl
// Sequencer for the clearing pass, request execution and decay sweeps.
// ----------------------------------------------------------------------------
module shiprrip_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output shiprrip_pkg::cmd_t    cmd,
  input  shiprrip_pkg::status_t status
);
  import shiprrip_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_SW_RD = 5'b01000,
    ST_SW_WR = 5'b10000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr     = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.clr_last) begin
          cmd.cnt_inc = 1'b0;
          cmd.cnt_clr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // A victim result waits here while the output register is full.
        if (!(status.is_victim && status.out_full)) begin
          cmd.exec = 1'b1;
          if (status.sweep_req) begin
            cmd.cnt_clr = 1'b1;
            state_next  = ST_SW_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SW_RD: begin
        cmd.sw_rd  = 1'b1;
        state_next = ST_SW_WR;
      end
      ST_SW_WR: begin
        cmd.sw_wr = 1'b1;
        if (status.set_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = ST_SW_RD;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: src/shiprrip_dp.sv
// ----------------------------------------------------------------------------
// shiprrip_dp
// Per-set state memories, victim selection, insertion logic, stride detector,
// miss counter, configuration registers and the result register.
// ----------------------------------------------------------------------------
module shiprrip_dp #(
  parameter int NUM_SETS       = 2048,
  parameter int NUM_WAYS       = 16,
  parameter int SIGNATURE_BITS = 6
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  shiprrip_pkg::cmd_t                    cmd,
  output shiprrip_pkg::status_t                 status,
  input  logic                                  cfg_wr_en,
  input  logic [shiprrip_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [shiprrip_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [shiprrip_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [shiprrip_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import shiprrip_pkg::*;

  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int SIG_N  = 1 << SIGNATURE_BITS;
  localparam int CLR_N  = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
  localparam int CNT_W  = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam int MOD_STEPS = SET_FIELD_W;

  typedef logic [NUM_WAYS-1:0][1:0]                rrpv_row_t;
  typedef logic [NUM_WAYS-1:0][SIGNATURE_BITS-1:0] bsig_row_t;
  typedef logic [STREAM_ENTRIES-1:0][ADDR_W-1:0]   wide_pair_t;
  typedef logic [STREAM_ENTRIES-1:0][1:0]          cnt_pair_t;

  // Memories.
  rrpv_row_t  rrpv_mem   [NUM_SETS];
  bsig_row_t  bsig_mem   [NUM_SETS];
  rrpv_row_t  dead_mem   [NUM_SETS];
  wide_pair_t la_mem     [NUM_SETS];
  wide_pair_t stride_mem [NUM_SETS];
  cnt_pair_t  rcnt_mem   [NUM_SETS];
  logic [1:0] so_mem     [SIG_N];

  // Registered read data.
  rrpv_row_t  rrpv_q, dead_q;
  wide_pair_t la_q, stride_q;
  cnt_pair_t  rcnt_q;
  logic [1:0] so_q;

  // Configuration registers and miss counter.
  logic [1:0]  stream_thr, reuse_thr;
  logic [15:0] decay_int, miss_cnt;
  logic [CNT_W-1:0] cnt;

  // Captured request.
  logic                      it_op, it_hit;
  logic [SET_W-1:0]          it_set;
  logic [WAY_FIELD_W-1:0]    it_way;
  logic [ADDR_W-1:0]         it_addr;
  logic [SIGNATURE_BITS-1:0] it_sig;

  // Request unpacking.
  logic [SET_FIELD_W-1:0]    in_set_raw;
  logic [SET_FIELD_W:0]      mod_r;
  logic [SET_W-1:0]          in_set;
  logic [ADDR_W-1:0]         in_addr;
  logic [15:0]               sig_wide;
  logic [SIGNATURE_BITS-1:0] in_sig;

  assign in_set_raw = s_tdata[SET_LSB +: SET_FIELD_W];
  assign in_addr    = s_tdata[ADDR_LSB +: ADDR_W];
  assign sig_wide   = {{(16 - PC_FIELD_W){1'b0}}, s_tdata[PC_LSB +: PC_FIELD_W]}
                      ^ in_addr[LINE_SHIFT +: 16];
  assign in_sig     = sig_wide[SIGNATURE_BITS-1:0];

  // Set index modulo the set count by constant compare-and-subtract steps.
  always_comb begin
    mod_r = {1'b0, in_set_raw};
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (32'(mod_r) >= (NUM_SETS << k)) begin
        mod_r = mod_r - (SET_FIELD_W + 1)'(NUM_SETS << k);
      end
    end
    in_set = SET_W'(mod_r);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_thr <= 2'd3;
      reuse_thr  <= 2'd2;
      decay_int  <= 16'd4096;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_STREAM_THR: stream_thr <= cfg_wdata[1:0];
        CFG_REUSE_THR:  reuse_thr  <= cfg_wdata[1:0];
        CFG_DECAY_INT:  decay_int  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_op   <= s_tuser;
      it_hit  <= s_tdata[HIT_LSB];
      it_set  <= in_set;
      it_way  <= s_tdata[WAY_LSB +: WAY_FIELD_W];
      it_addr <= in_addr;
      it_sig  <= in_sig;
    end
  end

  // Sweep and clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Victim selection: a saturated dead counter wins, else the first oldest way.
  // A dead way is evicted without aging the set.
  logic             dead_found, has3, has2, has1, max_found;
  logic [WAY_W-1:0] dead_ix, max_ix, vic_ix;
  logic [1:0]       top, age;
  rrpv_row_t        aged;

  always_comb begin
    dead_found = 1'b0;
    dead_ix    = '0;
    has3       = 1'b0;
    has2       = 1'b0;
    has1       = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!dead_found && dead_q[w] == CTR_MAX) begin
        dead_found = 1'b1;
        dead_ix    = WAY_W'(w);
      end
      has3 = has3 | (rrpv_q[w] == 2'd3);
      has2 = has2 | (rrpv_q[w] == 2'd2);
      has1 = has1 | (rrpv_q[w] == 2'd1);
    end
    top = has3 ? 2'd3 : has2 ? 2'd2 : has1 ? 2'd1 : 2'd0;
    age = RRPV_FAR - top;
    max_found = 1'b0;
    max_ix    = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!max_found && rrpv_q[w] == top) begin
        max_found = 1'b1;
        max_ix    = WAY_W'(w);
      end
      aged[w] = dead_found ? rrpv_q[w] : rrpv_q[w] + age;
    end
    vic_ix = dead_found ? dead_ix : max_ix;
  end

  // Stride detector.
  logic [ADDR_W-1:0] d0, d1;
  logic              m0, m1, streaming, repl_e;
  wide_pair_t        la_n, stride_n;
  cnt_pair_t         rcnt_n;
  logic [1:0]        sat_cnt;

  always_comb begin
    d0        = it_addr - la_q[0];
    d1        = it_addr - la_q[1];
    m0        = (stride_q[0] != '0) && (d0 == stride_q[0]);
    m1        = (stride_q[1] != '0) && (d1 == stride_q[1]);
    la_n      = la_q;
    stride_n  = stride_q;
    rcnt_n    = rcnt_q;
    streaming = 1'b0;
    sat_cnt   = '0;
    repl_e    = (la_q[0] <= la_q[1]) ? 1'b0 : 1'b1;
    if (m0) begin
      sat_cnt   = (rcnt_q[0] == CTR_MAX) ? CTR_MAX : rcnt_q[0] + 2'd1;
      rcnt_n[0] = sat_cnt;
      la_n[0]   = it_addr;
      streaming = (sat_cnt >= stream_thr);
    end else if (m1) begin
      sat_cnt   = (rcnt_q[1] == CTR_MAX) ? CTR_MAX : rcnt_q[1] + 2'd1;
      rcnt_n[1] = sat_cnt;
      la_n[1]   = it_addr;
      streaming = (sat_cnt >= stream_thr);
    end else if (repl_e) begin
      stride_n[1] = d1;
      la_n[1]     = it_addr;
      rcnt_n[1]   = 2'd1;
    end else begin
      stride_n[0] = d0;
      la_n[0]     = it_addr;
      rcnt_n[0]   = 2'd1;
    end
  end

  // Update of one way and its signature counter.
  logic             way_ok, upd_ok, miss_ok, ins_far, sweep_hit;
  logic [WAY_W-1:0] wix;
  logic [1:0]       so_n;
  logic [15:0]      miss_inc;
  rrpv_row_t        upd_rrpv, upd_dead, decayed;
  bsig_row_t        upd_bsig;

  always_comb begin
    way_ok   = (32'(it_way) < NUM_WAYS);
    wix      = WAY_W'(it_way);
    upd_ok   = (it_op == OP_UPDATE) && way_ok;
    miss_ok  = upd_ok && !it_hit;
    ins_far  = streaming || (so_q < reuse_thr);
    upd_rrpv = rrpv_q;
    upd_dead = dead_q;
    upd_bsig = '0;
    upd_bsig[wix] = it_sig;
    if (it_hit) begin
      upd_rrpv[wix] = 2'd0;
      upd_dead[wix] = 2'd0;
      so_n = (so_q == CTR_MAX) ? CTR_MAX : so_q + 2'd1;
    end else if (ins_far) begin
      upd_rrpv[wix] = RRPV_FAR;
      upd_dead[wix] = (dead_q[wix] == CTR_MAX) ? CTR_MAX : dead_q[wix] + 2'd1;
      so_n = (so_q == 2'd0) ? 2'd0 : so_q - 2'd1;
    end else begin
      upd_rrpv[wix] = 2'd0;
      so_n = so_q;
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      decayed[w] = (dead_q[w] == 2'd0) ? 2'd0 : dead_q[w] - 2'd1;
    end
    miss_inc  = miss_cnt + 16'd1;
    sweep_hit = (miss_inc == decay_int);
  end

  // Miss counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      miss_cnt <= '0;
    end else if (cmd.exec && miss_ok) begin
      miss_cnt <= sweep_hit ? 16'd0 : miss_inc;
    end
  end

  // Memory addressing and enables.
  logic             rd_en, in_sets, in_sigs, row_cnt_sel;
  logic [SET_W-1:0] rd_set, wr_set;
  logic [SIGNATURE_BITS-1:0] so_wa;

  assign rd_en       = cmd.load | cmd.sw_rd;
  assign rd_set      = cmd.load ? in_set : cnt[SET_W-1:0];
  assign row_cnt_sel = cmd.clr | cmd.sw_wr;
  assign wr_set      = row_cnt_sel ? cnt[SET_W-1:0] : it_set;
  assign in_sets     = cmd.clr && (32'(cnt) < NUM_SETS);
  assign in_sigs     = cmd.clr && (32'(cnt) < SIG_N);
  assign so_wa       = cmd.clr ? cnt[SIGNATURE_BITS-1:0] : it_sig;

  // Set memories: registered reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rrpv_q   <= rrpv_mem[rd_set];
      dead_q   <= dead_mem[rd_set];
      la_q     <= la_mem[rd_set];
      stride_q <= stride_mem[rd_set];
      rcnt_q   <= rcnt_mem[rd_set];
    end
    if (cmd.load) begin
      so_q <= so_mem[in_sig];
    end
  end

  // Set memories: writes.
  always_ff @(posedge clk) begin
    if (in_sets) begin
      rrpv_mem[wr_set] <= {NUM_WAYS{RRPV_FAR}};
    end else if (cmd.exec && (it_op == OP_VICTIM)) begin
      rrpv_mem[wr_set] <= aged;
    end else if (cmd.exec && upd_ok) begin
      rrpv_mem[wr_set] <= upd_rrpv;
    end

    if (in_sets) begin
      bsig_mem[wr_set] <= '0;
    end else if (cmd.exec && upd_ok) begin
      bsig_mem[wr_set][wix] <= upd_bsig[wix];
    end

    if (in_sets) begin
      dead_mem[wr_set] <= '0;
    end else if (cmd.sw_wr) begin
      dead_mem[wr_set] <= decayed;
    end else if (cmd.exec && upd_ok) begin
      dead_mem[wr_set] <= upd_dead;
    end

    if (in_sets) begin
      la_mem[wr_set]     <= '0;
      stride_mem[wr_set] <= '0;
    end else if (cmd.exec && miss_ok) begin
      la_mem[wr_set]     <= la_n;
      stride_mem[wr_set] <= stride_n;
    end

    if (in_sets || cmd.sw_wr) begin
      rcnt_mem[wr_set] <= '0;
    end else if (cmd.exec && miss_ok) begin
      rcnt_mem[wr_set] <= rcnt_n;
    end

    if (in_sigs) begin
      so_mem[so_wa] <= '0;
    end else if (cmd.exec && upd_ok) begin
      so_mem[so_wa] <= so_n;
    end
  end

  // Result register.
  logic [WAY_FIELD_W-1:0] out_way;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec && (it_op == OP_VICTIM)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (it_op == OP_VICTIM)) begin
      out_way <= WAY_FIELD_W'(vic_ix);
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - WAY_FIELD_W){1'b0}}, out_way};

  // Status to the controller.
  assign status.is_victim = (it_op == OP_VICTIM);
  assign status.out_full  = m_tvalid && !m_tready;
  assign status.sweep_req = miss_ok && sweep_hit;
  assign status.clr_last  = (cnt == CNT_W'(CLR_N - 1));
  assign status.set_last  = (cnt == CNT_W'(NUM_SETS - 1));

endmodule

// File: src/ship_rrip_dead_block_replacement.sv
// ----------------------------------------------------------------------------
// ship_rrip_dead_block_replacement
// Dead-block-aware 2-bit RRIP replacement with a signature insertion predictor.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                     Content
// s_*       in         tvalid tready tdata tuser   tuser: op; tdata: request fields
// m_*       out        tvalid tready tdata         tdata: victim way
// cfg_*     in         wr_en addr wdata            threshold and interval registers
//
// A request first reads its set row, then computes and writes it back through
// the single port of each set memory.
// After reset a clearing pass over max(NUM_SETS, 2**SIGNATURE_BITS) entries runs
// before the first request is taken.
// A decay sweep reads and writes back every set after the miss that triggers it.
// A victim request waits in execution while the result register is still full.
// ----------------------------------------------------------------------------
module ship_rrip_dead_block_replacement #(
  parameter int NUM_SETS       = 2048,
  parameter int NUM_WAYS       = 16,
  parameter int SIGNATURE_BITS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // set_index[10:0], way[14:11], address[78:15], pc_low_bits[84:79], hit[85]
  input  logic [shiprrip_pkg::IN_TDATA_W-1:0]  s_tdata,
  // op[0]
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // victim_way[3:0]
  output logic [shiprrip_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [shiprrip_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [shiprrip_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import shiprrip_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  shiprrip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // State memories and arithmetic.
  shiprrip_dp #(
    .NUM_SETS       (NUM_SETS),
    .NUM_WAYS       (NUM_WAYS),
    .SIGNATURE_BITS (SIGNATURE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`ifndef SYNTH
  // A request is followed by a busy state in which no request is taken.
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted in back-to-back cycles");

  // The sequencer issues at most one memory operation per cycle.
  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.exec, cmd.clr, cmd.sw_rd, cmd.sw_wr}))
    else $error("conflicting datapath commands");

  // The clearing pass follows reset before any request is taken.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request taken before the clearing pass");
`endif

endmodule
